// ===== design/wmo_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wmo_pkg
// Shared constants, codes and types of the wavetable mix oscillator.
// ============================================================================
package wmo_pkg;

    // Default sizing
    localparam int DEF_VOICES     = 4;
    localparam int DEF_TABLE_SIZE = 1024;

    // Voices that own step and gain registers
    localparam int REG_VOICES = 4;
    localparam int RV_W       = $clog2(REG_VOICES);

    // Field widths
    localparam int FRAC_W = 16;
    localparam int STEP_W = 26;
    localparam int GAIN_W = 9;
    localparam int SMP_W  = 8;
    localparam int VSEL_W = 2;
    localparam int TIDX_W = 10;

    localparam int SMP_MAX = (1 << SMP_W) - 1;

    // Gain of 256 is unity
    localparam int UNITY_SH    = 8;
    localparam int INTERP_W    = SMP_W + FRAC_W;
    localparam int SCALED_W    = INTERP_W + GAIN_W;
    localparam int ROUND_SH    = FRAC_W + UNITY_SH;
    localparam int VOICE_OUT_W = SCALED_W + 1 - ROUND_SH;

    // APB port
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    // Item commands
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Register map, one word each
    typedef enum logic [REG_IDX_W-1:0] {
        REG_STEP_V0,
        REG_STEP_V1,
        REG_STEP_V2,
        REG_STEP_V3,
        REG_GAIN_V0,
        REG_GAIN_V1,
        REG_GAIN_V2,
        REG_GAIN_V3
    } t_reg_idx;

    typedef logic [REG_VOICES-1:0][STEP_W-1:0] t_step_arr;
    typedef logic [REG_VOICES-1:0][GAIN_W-1:0] t_gain_arr;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_MUL_B,
        ST_SCALE,
        ST_ACCUM,
        ST_REDUCE,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic wr_table;
        logic start;
        logic rd_a;
        logic rd_b;
        logic mul_a;
        logic mul_b;
        logic scale;
        logic accum;
        logic reduce;
        logic advance;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic red_last;
        logic last_voice;
        logic out_free;
    } t_stat;

endpackage

// ===== design/wmo_in_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wmo_in_if
// Input channel: tick or table write transactions.
// ============================================================================
interface wmo_in_if;
    import wmo_pkg::*;

    logic              valid;
    logic              ready;
    logic              command;
    logic [VSEL_W-1:0] voice_select;
    logic [TIDX_W-1:0] table_index;
    logic [SMP_W-1:0]  table_value;

    modport source (
        output valid, command, voice_select, table_index, table_value,
        input  ready
    );

    modport sink (
        input  valid, command, voice_select, table_index, table_value,
        output ready
    );
endinterface

// ===== design/wmo_out_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wmo_out_if
// Output channel: one mixed sample transaction per tick.
// ============================================================================
interface wmo_out_if;
    import wmo_pkg::*;

    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] sample_out;
    logic             clipped;

    modport source (
        output valid, sample_out, clipped,
        input  ready
    );

    modport sink (
        input  valid, sample_out, clipped,
        output ready
    );
endinterface

// ===== design/wmo_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wmo_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module wmo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/wmo_regs.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wmo_regs
// APB register file holding the per-voice step and gain settings.
// ============================================================================
module wmo_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wmo_pkg::APB_AW-1:0]   paddr,
    input  logic [wmo_pkg::APB_DW-1:0]   pwdata,
    output logic [wmo_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output wmo_pkg::t_step_arr           o_step,
    output wmo_pkg::t_gain_arr           o_gain
);
    import wmo_pkg::*;

    t_step_arr r_step;
    t_gain_arr r_gain;
    t_reg_idx  w_idx;
    logic      w_wr;

    assign w_idx  = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_gain <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_STEP_V0: r_step[0] <= pwdata[STEP_W-1:0];
                REG_STEP_V1: r_step[1] <= pwdata[STEP_W-1:0];
                REG_STEP_V2: r_step[2] <= pwdata[STEP_W-1:0];
                REG_STEP_V3: r_step[3] <= pwdata[STEP_W-1:0];
                REG_GAIN_V0: r_gain[0] <= pwdata[GAIN_W-1:0];
                REG_GAIN_V1: r_gain[1] <= pwdata[GAIN_W-1:0];
                REG_GAIN_V2: r_gain[2] <= pwdata[GAIN_W-1:0];
                REG_GAIN_V3: r_gain[3] <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_STEP_V0: prdata = APB_DW'(r_step[0]);
            REG_STEP_V1: prdata = APB_DW'(r_step[1]);
            REG_STEP_V2: prdata = APB_DW'(r_step[2]);
            REG_STEP_V3: prdata = APB_DW'(r_step[3]);
            REG_GAIN_V0: prdata = APB_DW'(r_gain[0]);
            REG_GAIN_V1: prdata = APB_DW'(r_gain[1]);
            REG_GAIN_V2: prdata = APB_DW'(r_gain[2]);
            REG_GAIN_V3: prdata = APB_DW'(r_gain[3]);
            default:     prdata = '0;
        endcase
    end

    assign o_step = r_step;
    assign o_gain = r_gain;
endmodule

// ===== design/wmo_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wmo_ctrl
// Sequencer: walks each voice through read, interpolate, scale, accumulate
// and phase wrap, then hands the mixed sample to the output register.
// ============================================================================
module wmo_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_command,
    output logic            o_ready,
    input  wmo_pkg::t_stat  i_stat,
    output wmo_pkg::t_cmd   o_cmd
);
    import wmo_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign w_accept = i_valid && (r_state == ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (i_command == CMD_TICK)) begin
                    n_state = ST_RD_A;
                end
            end
            ST_RD_A:  n_state = ST_RD_B;
            ST_RD_B:  n_state = ST_MUL_B;
            ST_MUL_B: n_state = ST_SCALE;
            ST_SCALE: n_state = ST_ACCUM;
            ST_ACCUM: n_state = ST_REDUCE;
            ST_REDUCE: begin
                if (i_stat.red_last) begin
                    n_state = i_stat.last_voice ? ST_OUT : ST_RD_A;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready        = 1'b1;
                o_cmd.wr_table = w_accept && (i_command == CMD_WRITE);
                o_cmd.start    = w_accept && (i_command == CMD_TICK);
            end
            ST_RD_A: o_cmd.rd_a = 1'b1;
            ST_RD_B: begin
                o_cmd.rd_b  = 1'b1;
                o_cmd.mul_a = 1'b1;
            end
            ST_MUL_B: o_cmd.mul_b = 1'b1;
            ST_SCALE: o_cmd.scale = 1'b1;
            ST_ACCUM: o_cmd.accum = 1'b1;
            ST_REDUCE: begin
                o_cmd.reduce  = 1'b1;
                o_cmd.advance = i_stat.red_last;
            end
            ST_OUT: o_cmd.load_out = i_stat.out_free;
            default: ;
        endcase
    end
endmodule

// ===== design/wmo_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wmo_dp
// Datapath: wave table RAM, phase accumulators, interpolation and gain
// multipliers, modulo reduction unit, mix accumulator and output register.
// ============================================================================
module wmo_dp #(
    parameter int VOICES     = wmo_pkg::DEF_VOICES,
    parameter int TABLE_SIZE = wmo_pkg::DEF_TABLE_SIZE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  wmo_pkg::t_cmd                i_cmd,
    output wmo_pkg::t_stat               o_stat,
    input  logic [wmo_pkg::VSEL_W-1:0]   i_voice_select,
    input  logic [wmo_pkg::TIDX_W-1:0]   i_table_index,
    input  logic [wmo_pkg::SMP_W-1:0]    i_table_value,
    input  wmo_pkg::t_step_arr           i_step,
    input  wmo_pkg::t_gain_arr           i_gain,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [wmo_pkg::SMP_W-1:0]    o_sample_out,
    output logic                         o_clipped
);
    import wmo_pkg::*;

    // Phase is 10.16 style fixed point, wrapped modulo TABLE_SIZE << 16
    localparam longint MOD = longint'(TABLE_SIZE) << FRAC_W;
    localparam int PH_W      = $clog2(MOD);
    localparam int IDX_W     = PH_W - FRAC_W;
    localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int SW        = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;
    localparam int RW        = SW + 1;
    localparam int RED_STEPS = SW - PH_W + 1;
    localparam int KW        = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam int ACC_W     = VW + VOICE_OUT_W;
    localparam int AW        = VW + IDX_W;
    localparam int DEPTH     = 1 << AW;
    localparam logic [RW-1:0]       MOD_C  = RW'(MOD);
    localparam logic [SCALED_W:0]   HALF_C = (SCALED_W + 1)'(1) << (ROUND_SH - 1);

    // Control state
    logic [VW-1:0]   r_voice;
    logic [PH_W-1:0] r_phase [VOICES];
    logic [KW-1:0]   r_k;
    logic            r_out_valid;

    // Payload registers
    logic [INTERP_W-1:0] r_prod;
    logic [INTERP_W-1:0] r_interp;
    logic [SCALED_W-1:0] r_scaled;
    logic [ACC_W-1:0]    r_sum;
    logic [RW-1:0]       r_red;
    logic [SMP_W-1:0]    r_sample;
    logic                r_clipped;

    logic [31:0]           w_vs_ext;
    logic [31:0]           w_ti_ext;
    logic [31:0]           w_v_ext;
    logic                  w_wr_ok;
    logic [AW-1:0]         w_waddr;
    logic [AW-1:0]         w_raddr;
    logic [SMP_W-1:0]      w_rdata;
    logic [PH_W-1:0]       w_phase;
    logic [IDX_W-1:0]      w_idx;
    logic [IDX_W-1:0]      w_nxt;
    logic [FRAC_W-1:0]     w_frac;
    logic [FRAC_W:0]       w_wt_a;
    logic [INTERP_W:0]     w_prod_a;
    logic [INTERP_W-1:0]   w_prod_b;
    logic                  w_reg_voice;
    logic [STEP_W-1:0]     w_step;
    logic [GAIN_W-1:0]     w_gain;
    logic [SCALED_W:0]     w_rounded;
    logic [VOICE_OUT_W-1:0] w_vout;
    logic [RW-1:0]         w_mod_k;
    logic [RW-1:0]         w_red_next;

    // Table write decode; out-of-range voices and indexes are dropped
    assign w_vs_ext = 32'(i_voice_select);
    assign w_ti_ext = 32'(i_table_index);
    assign w_wr_ok  = (w_vs_ext < 32'(VOICES)) && (w_ti_ext < 32'(TABLE_SIZE));
    assign w_waddr  = {w_vs_ext[VW-1:0], w_ti_ext[IDX_W-1:0]};

    // Current voice phase, entry index and neighbor with wrap to zero
    assign w_phase = r_phase[r_voice];
    assign w_idx   = w_phase[PH_W-1:FRAC_W];
    assign w_frac  = w_phase[FRAC_W-1:0];
    assign w_nxt   = (({1'b0, w_idx} + (IDX_W + 1)'(1)) == (IDX_W + 1)'(TABLE_SIZE))
                   ? '0 : (w_idx + IDX_W'(1));
    assign w_raddr = {r_voice, (i_cmd.rd_b ? w_nxt : w_idx)};

    wmo_ram #(
        .WIDTH (SMP_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_table && w_wr_ok),
        .i_waddr (w_waddr),
        .i_wdata (i_table_value),
        .i_re    (i_cmd.rd_a || i_cmd.rd_b),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Step and gain of the current voice; voices without registers get zero
    assign w_v_ext     = 32'(r_voice);
    assign w_reg_voice = w_v_ext < 32'(REG_VOICES);
    assign w_step      = w_reg_voice ? i_step[w_v_ext[RV_W-1:0]] : '0;
    assign w_gain      = w_reg_voice ? i_gain[w_v_ext[RV_W-1:0]] : '0;

    // Interpolation products: a*(1-f) then b*f
    assign w_wt_a   = (FRAC_W + 1)'(1 << FRAC_W) - {1'b0, w_frac};
    assign w_prod_a = (INTERP_W + 1)'(w_rdata) * (INTERP_W + 1)'(w_wt_a);
    assign w_prod_b = INTERP_W'(w_rdata) * INTERP_W'(w_frac);

    // Round half up after gain
    assign w_rounded = {1'b0, r_scaled} + HALF_C;
    assign w_vout    = w_rounded[SCALED_W:ROUND_SH];

    // One conditional subtract of MOD << k per cycle
    assign w_mod_k    = MOD_C << r_k;
    assign w_red_next = (r_red >= w_mod_k) ? (r_red - w_mod_k) : r_red;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voice     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int v = 0; v < VOICES; v++) begin
                r_phase[v] <= '0;
            end
        end else begin
            if (i_cmd.start) begin
                r_voice <= '0;
            end else if (i_cmd.advance) begin
                r_phase[r_voice] <= w_red_next[PH_W-1:0];
                r_voice          <= r_voice + VW'(1);
            end
            if (i_cmd.accum) begin
                r_k <= KW'(RED_STEPS - 1);
            end else if (i_cmd.reduce) begin
                r_k <= r_k - KW'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Arithmetic pipeline
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_a) begin
            r_prod <= w_prod_a[INTERP_W-1:0];
        end
        if (i_cmd.mul_b) begin
            r_interp <= r_prod + w_prod_b;
        end
        if (i_cmd.scale) begin
            r_scaled <= SCALED_W'(r_interp) * SCALED_W'(w_gain);
        end
        if (i_cmd.start) begin
            r_sum <= '0;
        end else if (i_cmd.accum) begin
            r_sum <= r_sum + ACC_W'(w_vout);
        end
        if (i_cmd.accum) begin
            r_red <= RW'(w_phase) + RW'(w_step);
        end else if (i_cmd.reduce) begin
            r_red <= w_red_next;
        end
        if (i_cmd.load_out) begin
            if (r_sum > ACC_W'(SMP_MAX)) begin
                r_sample  <= SMP_W'(SMP_MAX);
                r_clipped <= 1'b1;
            end else begin
                r_sample  <= r_sum[SMP_W-1:0];
                r_clipped <= 1'b0;
            end
        end
    end

    assign o_stat.red_last   = (r_k == '0);
    assign o_stat.last_voice = (r_voice == VW'(VOICES - 1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample;
    assign o_clipped    = r_clipped;

`ifndef SYNTHESIS
    a_phase_wrapped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.advance |-> (w_red_next < MOD_C))
        else $error("phase written back without full wrap");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while held");

    a_clip_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_clipped) |-> (r_sample == SMP_W'(SMP_MAX)))
        else $error("clipped sample not saturated");

    a_start_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start |=> ((r_voice == '0) && (r_sum == '0)))
        else $error("tick did not restart voice walk");
`endif
endmodule

// ===== design/wavetable_mix_oscillator.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wavetable_mix_oscillator
// Multi-voice wavetable oscillator with linear interpolation, per-voice gain
// and a saturating 8-bit mix.
// ============================================================================
// A tick transaction walks every voice through two table reads, the
// interpolate and gain steps, accumulation and R modulo-reduction steps of
// the phase wrap unit before the next transaction can be accepted, where
// R = max(P, 26) + 2 - P with P = clog2(TABLE_SIZE) + 16; with the default
// four voices and 1024-entry tables R is 2.
// A tick is paced by the single read port of the table RAM (two reads per
// voice), the shared interpolate-and-gain multiplier chain that handles one
// voice at a time, and the one-subtract-per-cycle phase wrap unit. The mixed
// sample sits in an output register, so a new transaction is accepted while
// the previous sample waits. Tables are not cleared at reset: read an entry
// only after writing it. Step and gain registers reset to zero.
// ============================================================================
module wavetable_mix_oscillator #(
    parameter int VOICES     = wmo_pkg::DEF_VOICES,
    parameter int TABLE_SIZE = wmo_pkg::DEF_TABLE_SIZE
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    wmo_in_if.sink                      i_in,
    wmo_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wmo_pkg::APB_AW-1:0]  paddr,
    input  logic [wmo_pkg::APB_DW-1:0]  pwdata,
    output logic [wmo_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import wmo_pkg::*;

    t_cmd      w_cmd;
    t_stat     w_stat;
    t_step_arr w_step;
    t_gain_arr w_gain;
    logic      w_ready;

    assign i_in.ready = w_ready;

    // Configuration registers
    wmo_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_step  (w_step),
        .o_gain  (w_gain)
    );

    // Sequencer
    wmo_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_command (i_in.command),
        .o_ready   (w_ready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // Datapath
    wmo_dp #(
        .VOICES     (VOICES),
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_voice_select (i_in.voice_select),
        .i_table_index  (i_in.table_index),
        .i_table_value  (i_in.table_value),
        .i_step         (w_step),
        .i_gain         (w_gain),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_sample_out   (o_out.sample_out),
        .o_clipped      (o_out.clipped)
    );
endmodule

// ===== verif/wmo_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// wmo_checker
// Watches the tick/write and sample channels and the register port of the
// wavetable mix oscillator. It keeps its own tables, phases, steps and gains,
// predicts the mixed sample of every tick and compares it with the sample
// transactions leaving the block, in order.
// ============================================================================
module wmo_checker
    import wmo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    wmo_in_if                  i_in,
    wmo_out_if                 i_out,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [APB_AW-1:0]  i_paddr,
    input  logic [APB_DW-1:0]  i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [SMP_W-1:0] sample;
        logic             clip;
    } mix_sample_t;

    // Shadow state of the oscillator
    logic [SMP_W-1:0]  wave_mem [DEF_VOICES][DEF_TABLE_SIZE];
    logic [STEP_W-1:0] voice_phase [DEF_VOICES];
    t_step_arr         step_cfg;
    t_gain_arr         gain_cfg;

    mix_sample_t       mix_q [$];
    int                fail_total;

    // Mix one tick from the current phases, then advance every phase.
    // The phase is 10.16 and the table holds 2^10 entries, so the 26-bit
    // add wraps exactly at the table end.
    function automatic mix_sample_t mix_tick();
        longint unsigned   interp;
        longint unsigned   sum;
        logic [TIDX_W-1:0] idx;
        logic [TIDX_W-1:0] nxt;
        logic [FRAC_W-1:0] frac;
        mix_sample_t       res;
        int                v;
        sum = 0;
        for (v = 0; v < DEF_VOICES; v++) begin
            idx  = voice_phase[v][STEP_W-1:FRAC_W];
            frac = voice_phase[v][FRAC_W-1:0];
            nxt  = idx + TIDX_W'(1);    // last entry blends into entry 0
            interp = 64'(wave_mem[v][idx]) * (64'd1 << FRAC_W) - 64'(wave_mem[v][idx]) *
                     64'(frac) + 64'(wave_mem[v][nxt]) * 64'(frac);
            sum += (interp * 64'(gain_cfg[v]) + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
            voice_phase[v] = voice_phase[v] + step_cfg[v];
        end
        if (sum > SMP_MAX) begin
            res.sample = SMP_W'(SMP_MAX);
            res.clip   = 1'b1;
        end else begin
            res.sample = SMP_W'(sum);
            res.clip   = 1'b0;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        mix_sample_t want;
        t_reg_idx    ridx;
        int          v;
        if (!i_rst_n) begin
            for (v = 0; v < DEF_VOICES; v++) begin
                voice_phase[v] = '0;
            end
            step_cfg = '0;
            gain_cfg = '0;
            mix_q.delete();
            fail_total = 0;
        end else begin
            // sample transaction leaving the block: older than any tick taken now
            if (i_out.valid && i_out.ready) begin
                if (mix_q.size() == 0) begin
                    $error("unexpected sample transaction: sample_out %0d clipped %0d",
                           i_out.sample_out, i_out.clipped);
                    fail_total++;
                end else begin
                    want = mix_q.pop_front();
                    if (i_out.sample_out !== want.sample) begin
                        $error("sample_out mismatch: expected %0d, actual %0d",
                               want.sample, i_out.sample_out);
                        fail_total++;
                    end
                    if (i_out.clipped !== want.clip) begin
                        $error("clipped mismatch: expected %0d, actual %0d",
                               want.clip, i_out.clipped);
                        fail_total++;
                    end
                end
            end

            // register write, fields taken at their width
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                ridx = t_reg_idx'(i_paddr[APB_AW-1:2]);
                if (ridx < REG_GAIN_V0) begin
                    step_cfg[ridx] = i_pwdata[STEP_W-1:0];
                end else begin
                    gain_cfg[ridx - REG_GAIN_V0] = i_pwdata[GAIN_W-1:0];
                end
            end

            // tick or table write transaction
            if (i_in.valid && i_in.ready) begin
                if (i_in.command == CMD_WRITE) begin
                    wave_mem[i_in.voice_select][i_in.table_index] = i_in.table_value;
                end else begin
                    mix_q.push_back(mix_tick());
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= mix_q.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Stimulus for the wavetable mix oscillator: writes table entries on demand
// ahead of the ticks that read them, runs a short directed sequence over wrap,
// saturation and gain extremes, then random phases of ticks and table writes
// under several register settings, with bursty input traffic and a stalling
// sample receiver.
// ============================================================================
module testbench;
    import wmo_pkg::*;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int TICK_CYCLES   = 2 + DEF_VOICES * 7;
    localparam int SETTLE_CYCLES = TICK_CYCLES + 10;
    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 200;

    localparam logic [STEP_W-1:0] STEP_MAX   = '1;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = '1;
    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1 << UNITY_SH);

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} t_rx_mode;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    wmo_in_if  in_ch ();
    wmo_out_if out_ch ();

    int        fail_count;
    int        pending;
    int        burst_left;
    bit        gaps_on;
    t_rx_mode  rx_mode;
    int        rx_left = 0;
    int        idle_cycles = 0;
    int        items_sent;
    t_step_arr cfg_steps;
    t_gain_arr cfg_gains;
    t_step_arr live_steps;

    // Stimulus-side view of the phases and of which entries hold data
    logic [STEP_W-1:0] tb_phase [DEF_VOICES];
    bit                written [DEF_VOICES][DEF_TABLE_SIZE];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    wavetable_mix_oscillator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wmo_checker mix_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Sample receiver: switches between open, random, sparse and held stretches
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 40) : $urandom_range(1, 60);
        end
        rx_left--;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   out_ch.ready <= 1'b1;
                RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   out_ch.ready <= 1'b0;
            endcase
        end
    end

    // Watchdog: too long without any transaction ends the run
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("** wavetable_mix_oscillator: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [STEP_W-1:0] pick_step();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return STEP_MAX;
            2:       return STEP_W'($urandom_range(1, 32'h3FFFF));
            3:       return STEP_W'($urandom());
            4:       return STEP_W'($urandom_range(0, DEF_TABLE_SIZE - 1)) << FRAC_W;
            default: return STEP_W'($urandom_range(1, 32'hFFFF));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return GAIN_UNITY;
            2:       return GAIN_MAX;
            3:       return GAIN_W'($urandom_range(0, 1 << UNITY_SH));
            default: return GAIN_W'($urandom());
        endcase
    endfunction

    // Table samples lean toward the rails
    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return SMP_W'(SMP_MAX);
            default: return SMP_W'($urandom());
        endcase
    endfunction

    // One input transaction, sent in bursts with random gaps between them while gaps_on is set
    task automatic send_item(input logic cmd, input logic [VSEL_W-1:0] vsel,
                             input logic [TIDX_W-1:0] tidx, input logic [SMP_W-1:0] tval);
        int gap;
        int v;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = gaps_on ? $urandom_range(1, 20) : 0;
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.voice_select <= vsel;
        in_ch.table_index  <= tidx;
        in_ch.table_value  <= tval;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        // track what the block now holds
        items_sent++;
        if (cmd == CMD_WRITE) begin
            written[vsel][tidx] = 1'b1;
        end else begin
            for (v = 0; v < DEF_VOICES; v++) begin
                tb_phase[v] = tb_phase[v] + live_steps[v];
            end
        end
    endtask

    // A tick, preceded by writes of any entry it would read that holds no data yet
    task automatic send_tick(input logic [VSEL_W-1:0] vsel, input logic [TIDX_W-1:0] tidx,
                             input logic [SMP_W-1:0] tval);
        int                v;
        logic [TIDX_W-1:0] idx;
        logic [TIDX_W-1:0] nxt;
        for (v = 0; v < DEF_VOICES; v++) begin
            idx = tb_phase[v][STEP_W-1:FRAC_W];
            nxt = idx + TIDX_W'(1);
            if (!written[v][idx]) begin
                send_item(CMD_WRITE, VSEL_W'(v), idx, pick_sample());
            end
            if (!written[v][nxt]) begin
                send_item(CMD_WRITE, VSEL_W'(v), nxt, pick_sample());
            end
        end
        send_item(CMD_TICK, vsel, tidx, tval);
    endtask

    // Hold input until every sample has come out, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx ridx, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ridx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all step and gain registers; unused upper data bits get junk at times
    task automatic load_config(input t_step_arr steps, input t_gain_arr gains);
        logic [APB_DW-1:0] junk;
        int                v;
        for (v = 0; v < REG_VOICES; v++) begin
            junk = $urandom_range(0, 1) ? $urandom() : '0;
            apb_write(t_reg_idx'(REG_STEP_V0 + v), {junk[APB_DW-STEP_W-1:0], steps[v]});
        end
        for (v = 0; v < REG_VOICES; v++) begin
            junk = $urandom_range(0, 1) ? $urandom() : '0;
            apb_write(t_reg_idx'(REG_GAIN_V0 + v), {junk[APB_DW-GAIN_W-1:0], gains[v]});
        end
        live_steps = steps;
    endtask

    initial begin
        int v;
        int ph;
        int phase_end;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.command      <= CMD_TICK;
        in_ch.voice_select <= '0;
        in_ch.table_index  <= '0;
        in_ch.table_value  <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        burst_left = 0;
        gaps_on    = 1'b1;
        items_sent = 0;
        live_steps = '0;
        for (v = 0; v < DEF_VOICES; v++) begin
            tb_phase[v] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: backward wrap through the last entry, whole and half steps,
        // gain above unity, zero gain
        cfg_steps[0] = STEP_MAX;
        cfg_steps[1] = STEP_W'(1) << FRAC_W;
        cfg_steps[2] = STEP_W'(1) << (FRAC_W - 1);
        cfg_steps[3] = STEP_W'(1);
        cfg_gains[0] = GAIN_UNITY;
        cfg_gains[1] = GAIN_MAX;
        cfg_gains[2] = '0;
        cfg_gains[3] = GAIN_UNITY >> 1;
        load_config(cfg_steps, cfg_gains);
        send_item(CMD_WRITE, 2'd0, TIDX_W'(DEF_TABLE_SIZE - 1), SMP_W'(SMP_MAX));
        send_item(CMD_WRITE, 2'd0, '0, '0);
        send_item(CMD_WRITE, 2'd1, '0, SMP_W'(SMP_MAX));
        send_item(CMD_WRITE, 2'd1, TIDX_W'(1), SMP_W'(SMP_MAX));
        send_item(CMD_WRITE, 2'd2, '0, '0);
        send_item(CMD_WRITE, 2'd3, TIDX_W'(DEF_TABLE_SIZE - 1), SMP_W'(SMP_MAX / 2));
        repeat (8) send_tick('1, '1, '1);
        drain();

        // Directed: every gain at its maximum drives the mix into saturation
        for (v = 0; v < REG_VOICES; v++) begin
            cfg_gains[v] = GAIN_MAX;
        end
        cfg_steps[1] = '0;
        cfg_steps[2] = STEP_MAX;
        load_config(cfg_steps, cfg_gains);
        repeat (6) send_tick('0, '0, '0);

        // Random phases, each under its own register setting
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            for (v = 0; v < REG_VOICES; v++) begin
                cfg_steps[v] = pick_step();
                cfg_gains[v] = pick_gain();
            end
            load_config(cfg_steps, cfg_gains);
            gaps_on = (ph != 2);    // one phase runs back to back
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) == 0) begin
                    drain();
                end
                if ($urandom_range(0, 99) < 35) begin
                    send_item(CMD_WRITE, VSEL_W'($urandom()), TIDX_W'($urandom()),
                              pick_sample());
                end else begin
                    send_tick(VSEL_W'($urandom()), TIDX_W'($urandom()), SMP_W'($urandom()));
                end
            end
        end
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("** wavetable_mix_oscillator: PASSED **");
        end else begin
            $display("** wavetable_mix_oscillator: FAILED **");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/wmo_pkg.sv
design/wmo_in_if.sv
design/wmo_out_if.sv
design/wmo_ram.sv
design/wmo_regs.sv
design/wmo_ctrl.sv
design/wmo_dp.sv
design/wavetable_mix_oscillator.sv
verif/wmo_checker.sv
verif/testbench.sv
